### rtl/core/cmb_pkg.sv
// Shared widths, types and helper functions for the feedback comb filter core.
`default_nettype none

package cmb_pkg;

	localparam int DELAY_LENGTH = 100;
	localparam int POS_W        = (DELAY_LENGTH > 1) ? $clog2(DELAY_LENGTH) : 1;

	localparam int SAMPLE_W = 8;
	localparam int HIST_W   = 2 * SAMPLE_W;
	localparam int GAIN_W   = 6;
	localparam int DIGIT_W  = 2;
	localparam int MUL_DIGITS = GAIN_W / DIGIT_W;
	localparam int MUL_CNT_W  = (MUL_DIGITS > 1) ? $clog2(MUL_DIGITS) : 1;

	localparam int DIV_SHIFT = 4;
	localparam int MCAND_W   = 10;
	localparam int PP_W      = MCAND_W + DIGIT_W;
	localparam int PROD_W    = 16;
	localparam int QUOT_W    = PROD_W - DIV_SHIFT;
	localparam int SUM_W     = QUOT_W + 1;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	localparam logic [GAIN_W-1:0] GAIN_FIRST_RST  = GAIN_W'(23);
	localparam logic [GAIN_W-1:0] GAIN_SECOND_RST = GAIN_W'(10);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_FIRST  = CFG_IDX_W'(0),
		CFG_GAIN_SECOND = CFG_IDX_W'(1)
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL1,
		ST_MUL2,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                      start;
		logic signed [MCAND_W-1:0] mcand;
		logic [GAIN_W-1:0]         mplier;
	} mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

	// divide by 16, truncating toward zero
	function automatic logic [QUOT_W-1:0] div16_tz(input logic [PROD_W-1:0] v);
		logic [PROD_W-1:0] t;
		t = v + (v[PROD_W-1] ? PROD_W'((1 << DIV_SHIFT) - 1) : PROD_W'(0));
		return t[PROD_W-1:DIV_SHIFT];
	endfunction

	// clamp to the signed sample range
	function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [SUM_W-1:0] s);
		logic hi_ok;
		logic [SAMPLE_W-1:0] r;
		hi_ok = (s[SUM_W-1:SAMPLE_W-1] == '0) || (s[SUM_W-1:SAMPLE_W-1] == '1);
		if (hi_ok)
			r = s[SAMPLE_W-1:0];
		else if (s[SUM_W-1])
			r = {1'b1, {(SAMPLE_W-1){1'b0}}};
		else
			r = {1'b0, {(SAMPLE_W-1){1'b1}}};
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/cmb_smul.sv
// Digit-serial signed-by-unsigned multiplier, two multiplier bits per cycle, MSB first.
`default_nettype none

module cmb_smul (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire cmb_pkg::mul_req_t                req,
	output cmb_pkg::mul_stat_t                    stat,
	output logic signed [cmb_pkg::PROD_W-1:0]     product
);

	logic                                busy_q;
	logic                                done_q;
	logic [cmb_pkg::MUL_CNT_W-1:0]       cnt_q;
	logic signed [cmb_pkg::MCAND_W-1:0]  mcand_q;
	logic [cmb_pkg::GAIN_W-1:0]          mpl_q;
	logic signed [cmb_pkg::PROD_W-1:0]   acc_q;
	logic signed [cmb_pkg::DIGIT_W:0]    dig_s;
	logic signed [cmb_pkg::PP_W-1:0]     pp;

	always_comb begin
		dig_s = {1'b0, mpl_q[cmb_pkg::GAIN_W-1 -: cmb_pkg::DIGIT_W]};
		pp    = cmb_pkg::PP_W'(mcand_q) * cmb_pkg::PP_W'(dig_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmb_pkg::MUL_CNT_W'(cmb_pkg::MUL_DIGITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - cmb_pkg::MUL_CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q <= signed'(req.mcand);
			mpl_q   <= req.mplier;
			acc_q   <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q <<< cmb_pkg::DIGIT_W) + cmb_pkg::PROD_W'(pp);
			mpl_q <= mpl_q << cmb_pkg::DIGIT_W;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = acc_q;

endmodule

`default_nettype wire

### rtl/core/cmb_dline.sv
// Paired input/output delay line memory with shared position counter and fill flag.
`default_nettype none

module cmb_dline (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         we,
	input  wire logic [cmb_pkg::HIST_W-1:0]   wdata,
	output logic [cmb_pkg::HIST_W-1:0]        rdata
);

	logic [cmb_pkg::HIST_W-1:0] mem [cmb_pkg::DELAY_LENGTH];
	logic [cmb_pkg::HIST_W-1:0] rd_q;
	logic [cmb_pkg::POS_W-1:0]  pos_q;
	logic                       full_q;
	logic                       wrap;

	assign wrap = (pos_q == cmb_pkg::POS_W'(cmb_pkg::DELAY_LENGTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			full_q <= 1'b0;
		end else if (we) begin
			pos_q <= wrap ? '0 : pos_q + cmb_pkg::POS_W'(1);
			if (wrap)
				full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[pos_q] <= wdata;
		rd_q <= mem[pos_q];
	end

	// entries not yet written since reset read as zero
	assign rdata = full_q ? rd_q : '0;

endmodule

`default_nettype wire

### rtl/core/comb_reverb_filter_core.sv
// Top level of the feedback comb filter core: control, gain registers and output register.
//
//  channel   dir  handshake                  payload
//  sample    in   sample_valid/sample_stall  sample[7:0] signed
//  level     out  level_valid/level_stall    level[7:0] offset binary
//  cfg       in   cfg_valid/cfg_ready        cfg_index[3:0], cfg_data[7:0]
//
// Each item passes from transfer to result in order: one delay line read, two
// digit-serial multiplies (2 gain bits per cycle), one store. The next sample is
// taken in the cycle after the result has moved to the output register.
// Reset clears position, fill flag and all handshake state; it sets the gains to 23 and 10.
// A stalled result holds in the output register; cfg_ready is always high.
`default_nettype none

module comb_reverb_filter_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               sample_valid,
	output logic                                    sample_stall,
	input  wire logic signed [cmb_pkg::SAMPLE_W-1:0] sample,
	output logic                                    level_valid,
	input  wire logic                               level_stall,
	output logic [cmb_pkg::SAMPLE_W-1:0]            level,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [cmb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [cmb_pkg::CFG_DATA_W-1:0]     cfg_data
);

	cmb_pkg::state_t              state_q, state_d;
	logic [cmb_pkg::GAIN_W-1:0]   gain_first_q;
	logic [cmb_pkg::GAIN_W-1:0]   gain_second_q;
	logic [cmb_pkg::SAMPLE_W-1:0] x_q;
	logic [cmb_pkg::SAMPLE_W-1:0] dx_q;
	logic [cmb_pkg::SAMPLE_W-1:0] sat_q;
	logic [cmb_pkg::SAMPLE_W-1:0] level_q;
	logic                         level_valid_q;

	cmb_pkg::mul_req_t             mul_req;
	cmb_pkg::mul_stat_t            mul_stat;
	logic signed [cmb_pkg::PROD_W-1:0] mul_prod;

	logic                          dl_we;
	logic [cmb_pkg::HIST_W-1:0]    dl_rdata;
	logic [cmb_pkg::SAMPLE_W-1:0]  dy;
	logic [cmb_pkg::QUOT_W-1:0]    quot;
	logic [cmb_pkg::SUM_W-1:0]     sum;
	logic                          accept;
	logic                          out_load;
	logic                          out_free;

	assign dy   = dl_rdata[cmb_pkg::SAMPLE_W-1:0];
	assign quot = cmb_pkg::div16_tz(mul_prod);
	assign sum  = {quot[cmb_pkg::QUOT_W-1], quot}
	            + {{(cmb_pkg::SUM_W-cmb_pkg::SAMPLE_W){dx_q[cmb_pkg::SAMPLE_W-1]}}, dx_q};

	assign accept   = sample_valid && !sample_stall;
	assign out_free = !level_valid_q || !level_stall;

	cmb_smul u_smul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.stat    (mul_stat),
		.product (mul_prod)
	);

	cmb_dline u_dline (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (dl_we),
		.wdata  ({x_q, sat_q}),
		.rdata  (dl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= cmb_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d        = state_q;
		sample_stall   = 1'b1;
		mul_req.start  = 1'b0;
		mul_req.mcand  = quot[cmb_pkg::MCAND_W-1:0];
		mul_req.mplier = gain_second_q;
		dl_we          = 1'b0;
		out_load       = 1'b0;
		unique case (state_q)
			cmb_pkg::ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid)
					state_d = cmb_pkg::ST_LOAD;
			end
			cmb_pkg::ST_LOAD: begin
				mul_req.start  = 1'b1;
				mul_req.mcand  = {{(cmb_pkg::MCAND_W-cmb_pkg::SAMPLE_W){dy[cmb_pkg::SAMPLE_W-1]}},
				                  dy};
				mul_req.mplier = gain_first_q;
				state_d        = cmb_pkg::ST_MUL1;
			end
			cmb_pkg::ST_MUL1: begin
				if (mul_stat.done) begin
					mul_req.start = 1'b1;
					state_d       = cmb_pkg::ST_MUL2;
				end
			end
			cmb_pkg::ST_MUL2: begin
				if (mul_stat.done)
					state_d = cmb_pkg::ST_FIN;
			end
			cmb_pkg::ST_FIN: begin
				if (out_free) begin
					dl_we    = 1'b1;
					out_load = 1'b1;
					state_d  = cmb_pkg::ST_IDLE;
				end
			end
			default: state_d = cmb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_first_q  <= cmb_pkg::GAIN_FIRST_RST;
			gain_second_q <= cmb_pkg::GAIN_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == cmb_pkg::CFG_GAIN_FIRST)
				gain_first_q <= cfg_data[cmb_pkg::GAIN_W-1:0];
			else if (cfg_index == cmb_pkg::CFG_GAIN_SECOND)
				gain_second_q <= cfg_data[cmb_pkg::GAIN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			level_valid_q <= 1'b0;
		else if (out_load)
			level_valid_q <= 1'b1;
		else if (!level_stall)
			level_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			x_q <= sample;
		if (state_q == cmb_pkg::ST_LOAD)
			dx_q <= dl_rdata[cmb_pkg::HIST_W-1:cmb_pkg::SAMPLE_W];
		if (state_q == cmb_pkg::ST_MUL2 && mul_stat.done)
			sat_q <= cmb_pkg::sat_sample(sum);
		if (out_load)
			level_q <= {~sat_q[cmb_pkg::SAMPLE_W-1], sat_q[cmb_pkg::SAMPLE_W-2:0]};
	end

	assign cfg_ready   = 1'b1;
	assign level_valid = level_valid_q;
	assign level       = level_q;

`ifndef SYNTHESIS
	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == cmb_pkg::ST_MUL1 || state_q == cmb_pkg::ST_MUL2))
		else $error("multiplier done outside a multiply phase");

	a_accept_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 mul_stat.busy)
		else $error("transfer did not start the first multiply");

	a_idle_no_mul: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_stall |-> !mul_stat.busy && !mul_stat.done)
		else $error("input open while multiplier active");

	a_store_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		dl_we |=> level_valid)
		else $error("stored result not presented");
`endif

endmodule

`default_nettype wire
